/* rtl/bank_controller_with_rtc_top_assert.svh */
// Assertion macros for the bank controller.
`ifndef BANK_CONTROLLER_WITH_RTC_TOP_ASSERT_SVH
`define BANK_CONTROLLER_WITH_RTC_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define BCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bcr assertion failed");

`define BCR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bcr assertion failed");

`else

`define BCR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`define BCR_ASSERT_NOW(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/bcr_pkg.sv */
`default_nettype none

package bcr_pkg;

    localparam int RAM_BANKS_DEFAULT = 4;
    localparam int RAM_BANK_BYTES    = 8192;
    localparam int RAM_OFFSET_BITS   = 13;
    localparam int ROM_ADDRESS_BITS  = 21;
    localparam int CFG_INDEX_BITS    = 1;
    localparam int CFG_DATA_BITS     = 7;

    localparam logic [20:0] ROM_MASK = 21'((64'd1 << ROM_ADDRESS_BITS) - 64'd1);
    localparam logic [21:0] TICKS_PER_SECOND = 22'd1048576;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    localparam logic [1:0] SRC_DATA = 2'd0;
    localparam logic [1:0] SRC_ROM  = 2'd1;
    localparam logic [1:0] SRC_NONE = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_ROM_BANK_MASK = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RAM_BANK_MASK = 1'd1;

    localparam logic [7:0] SEL_SECONDS = 8'd8;
    localparam logic [7:0] SEL_MINUTES = 8'd9;
    localparam logic [7:0] SEL_HOURS   = 8'd10;
    localparam logic [7:0] SEL_DAY_LOW = 8'd11;
    localparam logic [7:0] SEL_DAY_HI  = 8'd12;

    localparam logic [3:0] RAM_ENABLE_CODE = 4'hA;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [7:0]  tick_cycles;
    } req_item_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [1:0]  source;
        logic [20:0] rom_address;
    } rsp_item_t;

    typedef struct packed {
        logic [5:0] seconds;
        logic [5:0] minutes;
        logic [4:0] hours;
        logic [8:0] days;
        logic       carry;
        logic       halted;
    } clock_t;

endpackage

`default_nettype wire

/* rtl/bank_controller_with_rtc_top.sv */
`default_nettype none

// Banked cartridge controller with a real-time clock. One bus read, bus
// write or clock tick is taken per cycle, and its single result item is
// presented from the output register in the cycle after acceptance; the
// request side stalls only while that result is held by a stalled
// consumer. Cartridge RAM is a synchronous single-port store of
// RAM_BANKS x 8 KiB with a registered read; it has no reset and needs no
// clearing pass, so items are accepted from the first cycle after reset.
// Control registers and the whole seconds-to-days carry chain update in
// the cycle of the item.
module bank_controller_with_rtc_top #(
    parameter int RAM_BANKS = bcr_pkg::RAM_BANKS_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               req_valid,
    output logic                                    req_stall,
    input  wire bcr_pkg::req_item_t                 req,
    output logic                                    rsp_valid,
    input  wire logic                               rsp_stall,
    output bcr_pkg::rsp_item_t                      rsp,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [bcr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [bcr_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import bcr_pkg::*;

    `include "bank_controller_with_rtc_top_assert.svh"

    localparam int STORE_BYTES = RAM_BANKS * RAM_BANK_BYTES;
    localparam int RAM_ADDR_BITS = $clog2(STORE_BYTES);
    localparam logic [2:0] BANKS_C = 3'(RAM_BANKS);

    logic [6:0]  rom_bank_mask_reg;
    logic [1:0]  ram_bank_mask_reg;
    logic [3:0]  enable_reg, enable_next;
    logic [6:0]  rom_bank_reg, rom_bank_next;
    logic [7:0]  select_reg, select_next;
    logic [7:0]  latch_byte_reg, latch_byte_next;
    logic [20:0] subsec_reg, subsec_next;
    clock_t      clock_reg, clock_next;
    clock_t      latched_reg, latched_next;

    logic        rsp_valid_reg;
    rsp_item_t   rsp_reg, rsp_next;
    logic        use_ram_reg, use_ram_next;
    logic [7:0]  ram_q_reg;

    logic [7:0]  ram [STORE_BYTES];

    logic        accept;
    logic        ram_we, ram_re;
    logic [2:0]  bank_raw, bank_w1, bank_w2, bank_eff;
    logic [14:0] ram_index_full;
    logic [RAM_ADDR_BITS-1:0] ram_addr;
    logic        ram_enabled, sel_is_ram, in_ext;
    logic [6:0]  rom_bank_eff;
    logic [20:0] rom_full;
    logic [21:0] subsec_sum;
    logic        sec_carry, min_carry, hour_carry;
    logic [5:0]  sec_inc, min_inc;
    logic [4:0]  hour_inc;
    logic [9:0]  day_inc;

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign cfg_ready = 1'b1;

    assign ram_enabled = (enable_reg == RAM_ENABLE_CODE);
    assign sel_is_ram  = (select_reg[7:2] == 6'd0);
    assign in_ext      = (req.address[15:13] == 3'b101);

    always_comb
    begin
        bank_raw = {1'b0, select_reg[1:0] & ram_bank_mask_reg};
        bank_w1  = (bank_raw >= BANKS_C) ? bank_raw - BANKS_C : bank_raw;
        bank_w2  = (bank_w1 >= BANKS_C) ? bank_w1 - BANKS_C : bank_w1;
        bank_eff = (bank_w2 >= BANKS_C) ? bank_w2 - BANKS_C : bank_w2;
    end

    assign ram_index_full = {bank_eff[1:0], req.address[RAM_OFFSET_BITS-1:0]};
    assign ram_addr = ram_index_full[RAM_ADDR_BITS-1:0];
    assign ram_we = accept && req.command == CMD_WRITE && in_ext && ram_enabled
                    && sel_is_ram;
    assign ram_re = accept && req.command == CMD_READ && in_ext && ram_enabled
                    && sel_is_ram;

    assign rom_bank_eff = ((rom_bank_reg == 7'd0) ? 7'd1 : rom_bank_reg)
                          & rom_bank_mask_reg;
    assign rom_full = {rom_bank_eff, req.address[13:0]};

    // carry chain
    assign subsec_sum = {1'b0, subsec_reg} + {14'd0, req.tick_cycles};
    assign sec_carry  = subsec_sum >= TICKS_PER_SECOND;
    assign sec_inc    = clock_reg.seconds + 6'd1;
    assign min_carry  = sec_carry && sec_inc == 6'd60;
    assign min_inc    = clock_reg.minutes + 6'd1;
    assign hour_carry = min_carry && min_inc == 6'd60;
    assign hour_inc   = clock_reg.hours + 5'd1;
    assign day_inc    = {1'b0, clock_reg.days} + 10'd1;

    always_comb
    begin
        enable_next     = enable_reg;
        rom_bank_next   = rom_bank_reg;
        select_next     = select_reg;
        latch_byte_next = latch_byte_reg;
        subsec_next     = subsec_reg;
        clock_next      = clock_reg;
        latched_next    = latched_reg;
        rsp_next        = '{read_data: 8'd0, source: SRC_NONE, rom_address: 21'd0};
        use_ram_next    = 1'b0;

        if (req.command == CMD_READ)
        begin
            if (req.address[15] == 1'b0)
            begin
                rsp_next.source = SRC_ROM;
                if (req.address[14] == 1'b0)
                    rsp_next.rom_address = {5'd0, req.address} & ROM_MASK;
                else
                    rsp_next.rom_address = rom_full & ROM_MASK;
            end
            else if (in_ext)
            begin
                rsp_next.source = SRC_DATA;
                if (!ram_enabled)
                    rsp_next.read_data = 8'hFF;
                else
                begin
                    unique case (select_reg) inside
                        [8'd0:8'd3]: use_ram_next = 1'b1;
                        SEL_SECONDS: rsp_next.read_data = {2'd0, latched_reg.seconds};
                        SEL_MINUTES: rsp_next.read_data = {2'd0, latched_reg.minutes};
                        SEL_HOURS:   rsp_next.read_data = {3'd0, latched_reg.hours};
                        SEL_DAY_LOW: rsp_next.read_data = latched_reg.days[7:0];
                        SEL_DAY_HI:  rsp_next.read_data = {latched_reg.carry,
                                         latched_reg.halted, 5'd0, latched_reg.days[8]};
                        default:     rsp_next.read_data = 8'hFF;
                    endcase
                end
            end
            else
                rsp_next.source = SRC_DATA;
        end
        else if (req.command == CMD_WRITE)
        begin
            unique case (req.address[15:13])
                3'b000: enable_next = req.write_data[3:0];
                3'b001: rom_bank_next = req.write_data[6:0];
                3'b010: select_next = req.write_data;
                3'b011:
                begin
                    if (req.write_data == 8'd1 && latch_byte_reg == 8'd0)
                        latched_next = clock_reg;
                    latch_byte_next = req.write_data;
                end
                3'b101:
                begin
                    if (ram_enabled)
                    begin
                        unique case (select_reg) inside
                            SEL_SECONDS:
                            begin
                                clock_next.seconds = req.write_data[5:0];
                                subsec_next = 21'd0;
                            end
                            SEL_MINUTES: clock_next.minutes = req.write_data[5:0];
                            SEL_HOURS:   clock_next.hours = req.write_data[4:0];
                            SEL_DAY_LOW: clock_next.days = {clock_reg.days[8],
                                                            req.write_data};
                            SEL_DAY_HI:
                            begin
                                clock_next.days   = {req.write_data[0],
                                                     clock_reg.days[7:0]};
                                clock_next.halted = req.write_data[6];
                                clock_next.carry  = req.write_data[7];
                            end
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
        end
        else if (req.command == CMD_TICK && !clock_reg.halted)
        begin
            subsec_next = sec_carry ? 21'(subsec_sum - TICKS_PER_SECOND)
                                    : subsec_sum[20:0];
            if (sec_carry)
                clock_next.seconds = min_carry ? 6'd0 : sec_inc;
            if (min_carry)
                clock_next.minutes = hour_carry ? 6'd0 : min_inc;
            if (hour_carry)
            begin
                if (hour_inc == 5'd24)
                begin
                    clock_next.hours = 5'd0;
                    if (day_inc[9])
                    begin
                        clock_next.days  = 9'd0;
                        clock_next.carry = 1'b1;
                    end
                    else
                        clock_next.days = day_inc[8:0];
                end
                else
                    clock_next.hours = hour_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_bank_mask_reg <= 7'd1;
            ram_bank_mask_reg <= 2'd3;
            enable_reg        <= 4'd0;
            rom_bank_reg      <= 7'd1;
            select_reg        <= 8'd0;
            latch_byte_reg    <= 8'd0;
            subsec_reg        <= 21'd0;
            clock_reg         <= '0;
            latched_reg       <= '0;
            rsp_valid_reg     <= 1'b0;
            use_ram_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_ROM_BANK_MASK: rom_bank_mask_reg <= cfg_data[6:0];
                    CFG_RAM_BANK_MASK: ram_bank_mask_reg <= cfg_data[1:0];
                    default: ;
                endcase
            end
            if (accept)
            begin
                enable_reg     <= enable_next;
                rom_bank_reg   <= rom_bank_next;
                select_reg     <= select_next;
                latch_byte_reg <= latch_byte_next;
                subsec_reg     <= subsec_next;
                clock_reg      <= clock_next;
                latched_reg    <= latched_next;
                use_ram_reg    <= use_ram_next;
                rsp_valid_reg  <= 1'b1;
            end
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (ram_we)
            ram[ram_addr] <= req.write_data;
        if (ram_re)
            ram_q_reg <= ram[ram_addr];
    end

    assign rsp_valid = rsp_valid_reg;
    always_comb
    begin
        rsp = rsp_reg;
        if (use_ram_reg)
            rsp.read_data = ram_q_reg;
    end

    `BCR_ASSERT_NEXT(a_accept_gives_result, clk, rst_n, accept, rsp_valid)
    `BCR_ASSERT_NOW(a_hold_blocks_input, clk, rst_n, rsp_valid && rsp_stall, !accept)
    `BCR_ASSERT_NOW(a_ram_result_is_data, clk, rst_n, rsp_valid && use_ram_reg,
                    rsp_reg.source == SRC_DATA)

endmodule

`default_nettype wire
